// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/vm4_pkg.sv -----
// Types, constants and float helpers for the 4x4 vertex transform.
package vm4_pkg;
  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [31:0] FloatOne = 32'h3F80_0000;

  typedef enum logic {OP_POINT = 1'b0, OP_VECTOR = 1'b1} op_t;

  // unpacked operand: class flags plus significand with hidden bit
  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic [9:0]  exp;     // unbiased + 127, subnormals use 1
    logic [23:0] man;
  } fp_t;

  function automatic fp_t fp_unpack(input logic [31:0] b);
    fp_t r;
    r.sign    = b[31];
    r.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    r.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r.is_zero = (b[30:0] == 31'd0);
    r.exp     = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
    r.man     = {(b[30:23] != 8'd0), b[22:0]};
    return r;
  endfunction

  // Round a value sig * 2^(e - 127 - 48) with sticky in bit 0; sig is 50 bits,
  // e is a signed biased exponent such that a 1 in bit 48 means exponent e.
  function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                           input logic [49:0] sig);
    logic [5:0] lz;
    logic [49:0] n;
    logic signed [11:0] ex;
    logic [11:0] sh;
    logic [50:0] d;
    logic [24:0] m;
    logic g, st;
    logic [31:0] r;
    lz = 6'd0;
    for (int i = 0; i < 50; i++) if (sig[i]) lz = 6'(49 - i);
    n = sig << lz;
    ex = e + 12'sd1 - 12'(lz);
    // n[49] now holds leading one at exponent ex
    if (ex < 12'sd1) begin
      sh = 12'(12'sd1 - ex);
      if (sh > 12'd50) sh = 12'd50;
      d = {n, 1'b0} >> sh;
      st = ({n, 1'b0} & ~({51{1'b1}} << sh)) != 51'd0;
      n = d[50:1];
      st = st | d[0];
      ex = 12'sd0;
    end else st = 1'b0;
    m  = {1'b0, n[49:26]};
    g  = n[25];
    st = st | (n[24:0] != 25'd0);
    if (g && (st || m[0])) m = m + 25'd1;
    if (m[24]) begin m = m >> 1; ex = ex + 12'sd1; end
    else if (ex == 12'sd0 && m[23]) ex = 12'sd1;
    if (sig == 50'd0) r = {s, 31'd0};
    else if (ex >= 12'sd255) r = {s, 8'hFF, 23'd0};
    else r = {s, ex[7:0], m[22:0]};
    return r;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    fp_t x, y;
    logic [47:0] p;
    logic s;
    logic [31:0] r;
    x = fp_unpack(a);
    y = fp_unpack(b);
    s = x.sign ^ y.sign;
    p = x.man * y.man;
    if (x.is_nan || y.is_nan || (x.is_inf && y.is_zero) || (y.is_inf && x.is_zero))
      r = CanonNan;
    else if (x.is_inf || y.is_inf) r = {s, 8'hFF, 23'd0};
    else if (x.is_zero || y.is_zero) r = {s, 31'd0};
    else r = fp_round(s, 12'($signed({2'b0, x.exp}) + $signed({2'b0, y.exp})) - 12'sd127
                      + 12'sd0, {1'b0, p, 1'b0} << 1);
    return r;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    fp_t x, y, hi, lo;
    logic [9:0] de;
    logic [49:0] mh, ml, sum;
    logic sl, s;
    logic [31:0] r;
    x = fp_unpack(a);
    y = fp_unpack(b);
    if ({x.exp, x.man} >= {y.exp, y.man}) begin hi = x; lo = y; end
    else begin hi = y; lo = x; end
    de = hi.exp - lo.exp;
    mh = {1'b0, hi.man, 25'd0};
    if (de > 10'd49) begin ml = 50'd0; sl = (lo.man != 24'd0); end
    else begin
      ml = {1'b0, lo.man, 25'd0} >> de;
      sl = (({1'b0, lo.man, 25'd0} & ~({50{1'b1}} << de)) != 50'd0);
    end
    if (hi.sign == lo.sign) sum = mh + ml;
    else sum = mh - ml - {49'd0, sl};
    sum[0] = sum[0] | sl;
    s = hi.sign;
    if (x.is_nan || y.is_nan || (x.is_inf && y.is_inf && x.sign != y.sign)) r = CanonNan;
    else if (x.is_inf) r = a;
    else if (y.is_inf) r = b;
    else if (x.is_zero && y.is_zero) r = {x.sign & y.sign, 31'd0};
    else if (sum == 50'd0) r = 32'd0;
    else r = fp_round(s, 12'($signed({2'b0, hi.exp})), sum);
    return r;
  endfunction
endpackage

// ----- rtl/vector_matrix4x4_transform.sv -----
// Top level of the single-precision 4x4 vertex transform.
// Pipeline: an accepted request passes the multiply, add and add stages in turn.
// Throughput: one vector per cycle; the whole pipeline advances when the
// output stage is empty or taken.
// Reset: synchronous; clears valid bits and loads the identity matrix.
`include "assert_macros.svh"
module vector_matrix4x4_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [31:0] in_x, in_y, in_z, in_w,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x, out_y, out_z, out_w,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [vm4_pkg::RegIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import vm4_pkg::*;
  logic [63:0] regs [NumRegs];
  logic [31:0] m [16];
  logic [2:0] vld;
  logic [2:0] pt;
  logic adv;
  logic [31:0] r [4];

  assign cfg_ready = 1'b1;
  assign adv = !vld[2] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= 64'd0;
      regs[0] <= {32'd0, FloatOne};
      regs[2] <= {FloatOne, 32'd0};
      regs[5] <= {32'd0, FloatOne};
      regs[7] <= {FloatOne, 32'd0};
      vld <= 3'd0;
    end else begin
      if (cfg_valid) regs[cfg_index] <= cfg_data;
      if (adv) vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) pt <= {pt[1:0], (operation == OP_POINT)};
  end

  always_comb begin
    for (int i = 0; i < 16; i++) m[i] = regs[i/2][32*(i%2) +: 32];
  end

  for (genvar j = 0; j < 4; j++) begin : g_col
    vm4_column u_col (
      .clk(clk), .adv(adv), .point(operation == OP_POINT),
      .x(in_x), .y(in_y), .z(in_z), .w(in_w),
      .m0(m[j]), .m1(m[4+j]), .m2(m[8+j]), .m3(m[12+j]),
      .res(r[j])
    );
  end

  assign out_x = r[0];
  assign out_y = r[1];
  assign out_z = r[2];
  assign out_w = pt[2] ? 32'd0 : r[3];

  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_x), "result lost")
  `ASSERT_IMPL(a_flow, in_valid && in_ready, adv, "accept without advance")
  `ASSERT_NEXT(a_fill, in_valid && in_ready, vld[0], "valid bit not set")
endmodule

// ----- rtl/vm4_column.sv -----
// One result column: multiply stage, two add stages, with stall-held registers.
module vm4_column (
  input  logic        clk,
  input  logic        adv,
  input  logic        point,
  input  logic [31:0] x, y, z, w,
  input  logic [31:0] m0, m1, m2, m3,
  output logic [31:0] res
);
  import vm4_pkg::*;
  logic [31:0] p0, p1, p2, p3, s0, s1;
  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= fp_mul(x, m0);
      p1 <= fp_mul(y, m1);
      p2 <= fp_mul(z, m2);
      p3 <= point ? m3 : fp_mul(w, m3);
      s0 <= fp_add(p0, p1);
      s1 <= fp_add(p2, p3);
      res <= fp_add(s0, s1);
    end
  end
endmodule

// ----- tb/vector_matrix4x4_transform_tb.sv -----
// Self-checking testbench for the single-precision 4x4 vertex transform.
module vector_matrix4x4_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vm4_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] x, y, z, w;
  } vec_req_t;

  typedef struct {
    logic [31:0] x, y, z, w;
  } vec_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [31:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_x, out_y, out_z, out_w;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [RegIdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  vector_matrix4x4_transform i_dut (.*);

  logic [63:0] matrix_shadow [NumRegs];
  vec_req_t    pending_reqs[$];
  vec_res_t    expected_vecs[$];
  int          mismatches = 0;
  int          hold_req = 0;

  logic [31:0] edge_vals [12] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000,
                                  32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
                                  32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000};

  initial forever #6 clk = ~clk;

  // ---- float predictor: exact in double, then one rounding to single ----
  function automatic real sp_to_real(logic [31:0] b);
    logic [63:0] d;
    logic [22:0] m;
    int p;
    m = b[22:0];
    p = 0;
    if (b[30:23] == 8'hFF) d = {b[31], 11'h7FF, m, 29'd0};
    else if (b[30:23] != 8'd0) d = {b[31], 11'(b[30:23] + 896), m, 29'd0};
    else if (m == 23'd0) d = {b[31], 63'd0};
    else begin
      for (int i = 0; i < 23; i++) if (m[i]) p = i;
      d = {b[31], 11'(p - 149 + 1023), 52'({m, 29'd0} << (23 - p))};
    end
    return $bitstoreal(d);
  endfunction

  // err is the part of the exact value that the double v could not hold
  function automatic logic [31:0] real_to_sp(real v, real err);
    logic [63:0] d;
    logic [52:0] sig;
    logic [30:0] mag;
    logic g, st;
    int e, k;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 52'd0) ? CanonNan : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023;
    sig = {1'b1, d[51:0]};
    if (e > 127) return {d[63], 8'hFF, 23'd0};
    if (e >= -126) begin
      mag = {8'(e + 127), sig[51:29]};
      g = sig[28];
      st = |sig[27:0];
    end else begin
      k = 29 + (-126 - e);
      if (k > 53) begin
        mag = '0; g = 1'b0; st = 1'b1;
      end else begin
        mag = 31'(sig >> k);
        g = sig[k-1];
        st = (sig & ((53'd1 << (k - 1)) - 53'd1)) != 53'd0;
      end
    end
    // a double sitting on a halfway point: the residual decides the direction
    if (g && !st && err != 0.0) begin
      if ((err > 0.0) == (d[63] == 1'b0)) st = 1'b1;
      else g = 1'b0;
    end
    // carry out of the fraction rolls into the exponent field, up to inf
    if (g && (st || mag[0])) mag = mag + 31'd1;
    return {d[63], mag};
  endfunction

  function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b), 0.0);
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
    real ra, rb, s, bv, err;
    ra = sp_to_real(a);
    rb = sp_to_real(b);
    s = ra + rb;
    bv = s - ra;
    err = (ra - (s - bv)) + (rb - bv);
    return real_to_sp(s, err);
  endfunction

  function automatic logic [31:0] elem_bits(int idx);
    logic [63:0] r;
    r = matrix_shadow[idx >> 1];
    return idx[0] ? r[63:32] : r[31:0];
  endfunction

  function automatic logic [31:0] column_dot(int j, vec_req_t q);
    logic [31:0] p0, p1, p2, p3;
    p0 = sp_mul(q.x, elem_bits(j));
    p1 = sp_mul(q.y, elem_bits(4 + j));
    p2 = sp_mul(q.z, elem_bits(8 + j));
    p3 = (q.op == OP_POINT) ? elem_bits(12 + j) : sp_mul(q.w, elem_bits(12 + j));
    return sp_add(sp_add(p0, p1), sp_add(p2, p3));
  endfunction

  function automatic vec_res_t transform_vec(vec_req_t q);
    vec_res_t r;
    r.x = column_dot(0, q);
    r.y = column_dot(1, q);
    r.z = column_dot(2, q);
    r.w = (q.op == OP_POINT) ? 32'd0 : column_dot(3, q);
    return r;
  endfunction

  // ---- stimulus values ----
  function automatic logic [31:0] rand_float();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
    if (pick < 75) return edge_vals[$urandom_range(0, 11)];
    if (pick < 85) return {1'($urandom), 8'd0, 23'($urandom)};
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_elem(int kind);
    case (kind)
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
      3: return rand_float();
      4: return ($urandom_range(0, 1) == 1) ? {1'($urandom), 31'h7F7F_FFFF}
                                             : {1'($urandom), 31'h0000_0001};
      default: return $urandom;
    endcase
  endfunction

  // ---- input driver ----
  vec_req_t cur_req;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_vecs.push_back(transform_vec(cur_req));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          operation <= cur_req.op;
          in_x <= cur_req.x;
          in_y <= cur_req.y;
          in_z <= cur_req.z;
          in_w <= cur_req.w;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result side: stall pattern plus a long hold-off on request ----
  int hold_seen = 0;
  int hold_cnt = 0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen++;
      hold_cnt = 400;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---- result checker ----
  always @(posedge clk) begin
    vec_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_vecs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h %h %h %h", out_x, out_y, out_z, out_w);
      end else begin
        e = expected_vecs.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_z !== e.z || out_w !== e.w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %h, got %h %h %h %h",
                     e.x, e.y, e.z, e.w, out_x, out_y, out_z, out_w);
        end
      end
    end
  end

  // ---- sequencing ----
  task automatic write_matrix_reg(int idx, logic [63:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= RegIdxW'(idx);
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    matrix_shadow[idx] = data;
  endtask

  // sampled mid-cycle so the driver's updates at the edge have settled
  task automatic drain_pipeline();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_vecs.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    vec_req_t q;
    int kind;
    for (int i = 0; i < NumRegs; i++) matrix_shadow[i] = 64'd0;
    matrix_shadow[0] = {32'd0, FloatOne};
    matrix_shadow[2] = {FloatOne, 32'd0};
    matrix_shadow[5] = {32'd0, FloatOne};
    matrix_shadow[7] = {FloatOne, 32'd0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // edge values through the reset identity, both modes
    for (int i = 0; i < 24; i++) begin
      q.op = (i % 2 == 0) ? OP_POINT : OP_VECTOR;
      q.x = edge_vals[(i / 2) % 12];
      q.y = edge_vals[(i / 2 + 3) % 12];
      q.z = edge_vals[(i / 2 + 5) % 12];
      q.w = edge_vals[(i / 2 + 7) % 12];
      pending_reqs.push_back(q);
    end
    drain_pipeline();

    for (int phase = 0; phase < 7; phase++) begin
      kind = (phase < 6) ? phase : 3;
      for (int r = 0; r < NumRegs; r++) write_matrix_reg(r, {rand_elem(kind), rand_elem(kind)});
      for (int n = 0; n < 240; n++) begin
        q.op = op_t'($urandom_range(0, 1));
        q.x = rand_float();
        q.y = rand_float();
        q.z = rand_float();
        q.w = rand_float();
        pending_reqs.push_back(q);
      end
      if (phase == 3) hold_req++;
      drain_pipeline();
    end

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
